// ----- rtl/prs_pkg.sv -----
// ----------------------------------------------------------------------------
// prs_pkg
// Shared sizes, command and status codes, and channel / control types for the
// received packet store.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int MAX_PACKETS_P = 16;
  localparam int MAX_FLITS     = 16;

  localparam int SLOT_W = $clog2(MAX_PACKETS_P);
  localparam int TOP_W  = $clog2(MAX_PACKETS_P + 1);
  localparam int CNT_W  = $clog2(MAX_FLITS + 1);
  localparam int FIDX_W = (MAX_FLITS > 1) ? $clog2(MAX_FLITS) : 1;
  localparam int ADDR_W = SLOT_W + FIDX_W;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_COMMIT = 3'd1;
  localparam logic [2:0] CMD_PEEK   = 3'd2;
  localparam logic [2:0] CMD_POP    = 3'd3;
  localparam logic [2:0] CMD_TAKE   = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] flit_word;
    logic [7:0]  packet_tag;
  } in_item_t;

  typedef struct packed {
    logic [63:0] flit_out;
    logic [7:0]  tag_out;
    logic [4:0]  flits_in_packet;
    logic [4:0]  stored_packets;
    logic        has_flit;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       accept;
    logic       emit_single;
    logic       apply;
    logic [1:0] single_status;
    logic       search_step;
    logic       rd_issue;
    logic       emit_pkt;
    logic       compact;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] command;
    logic       full;
    logic       empty;
    logic       pkt_full;
    logic       tag_hit;
    logic       search_end;
    logic       cnt_zero;
    logic       flit_last;
    logic       pending;
    logic       out_free;
  } dp_stat_t;

endpackage

// ----- rtl/prs_datapath.sv -----
// ----------------------------------------------------------------------------
// prs_datapath
// Slot tables, buffer map, flit memory and the result register of the packet
// store. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module prs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  prs_pkg::in_item_t   item,
  input  prs_pkg::dp_cmd_t    cmd,
  output prs_pkg::dp_stat_t   stat,
  input  logic                result_stall,
  output logic                result_valid,
  output prs_pkg::out_item_t  result
);

  logic [prs_pkg::TOP_W-1:0]  top;
  logic [prs_pkg::CNT_W-1:0]  counts [prs_pkg::MAX_PACKETS_P];
  logic [7:0]                 tags   [prs_pkg::MAX_PACKETS_P];
  // logical slot -> physical flit buffer, so compaction never copies flits
  logic [prs_pkg::SLOT_W-1:0] bmap   [prs_pkg::MAX_PACKETS_P];

  logic [2:0]                 cmd_r;
  logic [63:0]                word_r;
  logic [7:0]                 tag_r;
  logic [prs_pkg::SLOT_W-1:0] sel;
  logic [prs_pkg::CNT_W-1:0]  fidx;
  logic                       pending;
  logic [63:0]                rdata;

  logic [63:0] mem [2**prs_pkg::ADDR_W];

  logic [prs_pkg::CNT_W-1:0]  cur_cnt;
  logic [7:0]                 cur_tag;
  logic [prs_pkg::SLOT_W-1:0] cur_buf;
  logic [prs_pkg::TOP_W-1:0]  top_m1;
  logic [prs_pkg::SLOT_W-1:0] hi_idx;
  logic [prs_pkg::ADDR_W-1:0] wr_addr;
  logic [prs_pkg::ADDR_W-1:0] rd_addr;
  logic                       mem_we;
  logic                       out_free;
  logic [prs_pkg::TOP_W-1:0]  single_stored;
  logic [prs_pkg::TOP_W-1:0]  pkt_stored;

  assign cur_cnt = counts[sel];
  assign cur_tag = tags[sel];
  assign cur_buf = bmap[sel];
  assign top_m1  = top - prs_pkg::TOP_W'(1);
  assign hi_idx  = (top == prs_pkg::TOP_W'(prs_pkg::MAX_PACKETS_P)) ?
                   prs_pkg::SLOT_W'(prs_pkg::MAX_PACKETS_P - 1) : top[prs_pkg::SLOT_W-1:0];
  assign wr_addr = {cur_buf, cur_cnt[prs_pkg::FIDX_W-1:0]};
  assign rd_addr = {cur_buf, fidx[prs_pkg::FIDX_W-1:0]};
  assign mem_we  = cmd.emit_single && cmd.apply && (cmd_r == prs_pkg::CMD_APPEND);
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    single_stored = top;
    if (cmd.apply && (cmd_r == prs_pkg::CMD_COMMIT)) begin
      single_stored = top + prs_pkg::TOP_W'(1);
    end else if (cmd.apply && (cmd_r == prs_pkg::CMD_POP)) begin
      single_stored = top_m1;
    end
    pkt_stored = (cmd_r == prs_pkg::CMD_TAKE) ? top_m1 : top;
  end

  always_comb begin
    stat.command    = cmd_r;
    stat.full       = (top == prs_pkg::TOP_W'(prs_pkg::MAX_PACKETS_P));
    stat.empty      = (top == '0);
    stat.pkt_full   = (cur_cnt >= prs_pkg::CNT_W'(prs_pkg::MAX_FLITS));
    stat.tag_hit    = (cur_tag == tag_r);
    stat.search_end = ((prs_pkg::TOP_W'(sel) + prs_pkg::TOP_W'(1)) == top);
    stat.cnt_zero   = (cur_cnt == '0);
    stat.flit_last  = (fidx == cur_cnt);
    stat.pending    = pending;
    stat.out_free   = out_free;
  end

  // request latch and slot pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= item.command;
      word_r <= item.flit_word;
      tag_r  <= item.packet_tag;
      fidx   <= '0;
      case (item.command)
        prs_pkg::CMD_PEEK, prs_pkg::CMD_POP: sel <= top_m1[prs_pkg::SLOT_W-1:0];
        prs_pkg::CMD_TAKE:                   sel <= '0;
        default:                             sel <= top[prs_pkg::SLOT_W-1:0];
      endcase
    end else begin
      if (cmd.search_step) sel <= sel + prs_pkg::SLOT_W'(1);
      if (cmd.rd_issue) fidx <= fidx + prs_pkg::CNT_W'(1);
    end
  end

  // slot tables
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      for (int k = 0; k < prs_pkg::MAX_PACKETS_P; k++) begin
        counts[k] <= '0;
        tags[k]   <= '0;
        bmap[k]   <= prs_pkg::SLOT_W'(k);
      end
    end else if (cmd.emit_single && cmd.apply) begin
      case (cmd_r)
        prs_pkg::CMD_APPEND: begin
          counts[sel] <= cur_cnt + prs_pkg::CNT_W'(1);
          tags[sel]   <= tag_r;
        end
        prs_pkg::CMD_COMMIT: top <= top + prs_pkg::TOP_W'(1);
        prs_pkg::CMD_POP: begin
          counts[sel] <= '0;
          tags[sel]   <= '0;
          top         <= top_m1;
        end
        default: ;
      endcase
    end else if (cmd.compact) begin
      // slots above the removed one shift down; its buffer goes to the top
      for (int k = 0; k < prs_pkg::MAX_PACKETS_P - 1; k++) begin
        if ((prs_pkg::SLOT_W'(k) >= sel) && (prs_pkg::SLOT_W'(k) < hi_idx)) begin
          counts[k] <= counts[k+1];
          tags[k]   <= tags[k+1];
          bmap[k]   <= bmap[k+1];
        end
      end
      counts[hi_idx] <= '0;
      tags[hi_idx]   <= '0;
      bmap[hi_idx]   <= cur_buf;
      top            <= top_m1;
    end
  end

  // flit memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= word_r;
    if (cmd.rd_issue) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (cmd.rd_issue) begin
      pending <= 1'b1;
    end else if (cmd.emit_pkt) begin
      pending <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_single || cmd.emit_pkt) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_single) begin
      result.flit_out        <= '0;
      result.tag_out         <= '0;
      result.flits_in_packet <= '0;
      result.stored_packets  <= 5'(single_stored);
      result.has_flit        <= 1'b0;
      result.status          <= cmd.single_status;
      result.last            <= 1'b1;
    end else if (cmd.emit_pkt) begin
      result.flit_out        <= stat.cnt_zero ? 64'd0 : rdata;
      result.tag_out         <= cur_tag;
      result.flits_in_packet <= 5'(cur_cnt);
      result.stored_packets  <= 5'(pkt_stored);
      result.has_flit        <= !stat.cnt_zero;
      result.status          <= prs_pkg::ST_OK;
      result.last            <= stat.flit_last;
    end
  end

endmodule

// ----- rtl/prs_ctrl.sv -----
// ----------------------------------------------------------------------------
// prs_ctrl
// Command sequencer of the packet store: decode, tag search, flit streaming
// and compaction.
// ----------------------------------------------------------------------------
module prs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  prs_pkg::dp_stat_t  stat,
  output prs_pkg::dp_cmd_t   cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXEC    = 6'b000010,
    S_SEARCH  = 6'b000100,
    S_STREAM  = 6'b001000,
    S_COMPACT = 6'b010000,
    S_SPARE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.command)
          prs_pkg::CMD_APPEND: begin
            if (stat.out_free) begin
              cmd.emit_single   = 1'b1;
              cmd.apply         = !(stat.full || stat.pkt_full);
              cmd.single_status = (stat.full || stat.pkt_full) ?
                                  prs_pkg::ST_FULL : prs_pkg::ST_OK;
              state_next        = S_IDLE;
            end
          end
          prs_pkg::CMD_COMMIT: begin
            if (stat.out_free) begin
              cmd.emit_single   = 1'b1;
              cmd.apply         = !stat.full;
              cmd.single_status = stat.full ? prs_pkg::ST_FULL : prs_pkg::ST_OK;
              state_next        = S_IDLE;
            end
          end
          prs_pkg::CMD_PEEK, prs_pkg::CMD_TAKE: begin
            if (!stat.empty) begin
              state_next = (stat.command == prs_pkg::CMD_PEEK) ? S_STREAM : S_SEARCH;
            end else if (stat.out_free) begin
              cmd.emit_single   = 1'b1;
              cmd.single_status = prs_pkg::ST_MISS;
              state_next        = S_IDLE;
            end
          end
          prs_pkg::CMD_POP: begin
            if (stat.out_free) begin
              cmd.emit_single   = 1'b1;
              cmd.apply         = !stat.empty;
              cmd.single_status = stat.empty ? prs_pkg::ST_MISS : prs_pkg::ST_OK;
              state_next        = S_IDLE;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.emit_single   = 1'b1;
              cmd.single_status = prs_pkg::ST_OK;
              state_next        = S_IDLE;
            end
          end
        endcase
      end
      S_SEARCH: begin
        // one committed slot per cycle, lowest first
        if (stat.tag_hit) begin
          state_next = S_STREAM;
        end else if (!stat.search_end) begin
          cmd.search_step = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit_single   = 1'b1;
          cmd.single_status = prs_pkg::ST_MISS;
          state_next        = S_IDLE;
        end
      end
      S_STREAM: begin
        // next read goes out in the cycle its predecessor is emitted
        if (!stat.pending && !stat.cnt_zero) begin
          cmd.rd_issue = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit_pkt = 1'b1;
          if (stat.flit_last) begin
            state_next = (stat.command == prs_pkg::CMD_TAKE) ? S_COMPACT : S_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
          end
        end
      end
      S_COMPACT: begin
        cmd.compact = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/packet_receive_store.sv -----
// ----------------------------------------------------------------------------
// packet_receive_store
// Stack of received packets with append, commit, peek, pop and take-by-tag.
//
//   channel  | payload      | handshake
//   ---------+--------------+------------------------------
//   item     | in_item_t    | item_valid / item_stall
//   result   | out_item_t   | result_valid / result_stall
//
// Append, commit, pop and unknown requests finish in the execute state.
// Peek streams the newest packet's flits; take searches up to 16 slots by
// tag, streams the match and compacts. Streaming runs one flit a cycle off
// the flit memory while the result is not stalled; the tag search visits
// one slot a cycle. Reset clears the top pointer, slot counts and tags; flit
// memory is not cleared. A stalled result holds the sequencer at each emit.
// ----------------------------------------------------------------------------
module packet_receive_store (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  prs_pkg::in_item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output prs_pkg::out_item_t  result
);

  prs_pkg::dp_cmd_t  cmd;
  prs_pkg::dp_stat_t stat;

  prs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  prs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ----- rtl/prs_checker.sv -----
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks for the packet store.
// ----------------------------------------------------------------------------
module prs_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input prs_pkg::out_item_t  result
);

  // a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // only one request in flight
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("request taken while another is in flight");

  // flit data is zero unless flagged
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_flit |-> result.flit_out == 64'd0)
    else $error("flit data without has_flit");

  // error results end the request and carry no flit
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != prs_pkg::ST_OK) |->
      result.last && !result.has_flit)
    else $error("error result not final");

endmodule

bind packet_receive_store prs_checker u_prs_checker (.*);
